/* hdl/rgbhsv_pkg.sv */
// shared constants and types for the rgb to hsv converter
// no dependencies; used by rgbhsv_div_stage and rgb_to_hsv_converter_core
package rgbhsv_pkg;

    // pixel and result formats
    localparam int PIX_BITS      = 8;
    localparam int HUE_BITS      = 16;
    localparam int SAT_FRAC_BITS = 16;

    // hue divisor is 6*d with d up to 255, needs 11 bits
    localparam int HUE_DIV_BITS  = PIX_BITS + 3;

    // divider pipeline shape: a few quotient bits per register stage
    localparam int STEPS_PER_STAGE = 4;
    localparam int DIV_STEPS  = (HUE_BITS > SAT_FRAC_BITS) ? HUE_BITS : SAT_FRAC_BITS;
    localparam int NUM_STAGES = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int QUO_BITS   = NUM_STAGES * STEPS_PER_STAGE;

    // saturation of exactly 1.0
    localparam logic [SAT_FRAC_BITS:0] SAT_ONE = (SAT_FRAC_BITS + 1)'(1) << SAT_FRAC_BITS;

    // partial state of both divisions as it moves down the pipeline
    typedef struct packed {
        logic [PIX_BITS-1:0]     s_rem;
        logic [PIX_BITS-1:0]     s_div;
        logic [QUO_BITS:0]       s_quo;
        logic [HUE_DIV_BITS-1:0] h_rem;
        logic [HUE_DIV_BITS-1:0] h_div;
        logic [QUO_BITS-1:0]     h_quo;
        logic [PIX_BITS-1:0]     val;
    } t_div;

endpackage

/* hdl/rgbhsv_div_stage.sv */
// one register stage of the saturation and hue dividers
// retires STEPS_PER_STAGE quotient bits of each division; uses rgbhsv_pkg
module rgbhsv_div_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rgbhsv_pkg::t_div  i_data,
    output logic              o_ready,
    output logic              o_valid,
    output rgbhsv_pkg::t_div  o_data,
    input  logic              i_ready
);

    logic             r_valid;
    rgbhsv_pkg::t_div r_data;
    rgbhsv_pkg::t_div n_data;
    logic             w_en;

    // stage loads when empty or when its beat moves on
    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // restoring division steps, both dividers side by side
    always_comb begin
        rgbhsv_pkg::t_div               v;
        logic [rgbhsv_pkg::PIX_BITS:0]     s2;
        logic [rgbhsv_pkg::HUE_DIV_BITS:0] h2;
        v  = i_data;
        s2 = '0;
        h2 = '0;
        for (int j = 0; j < rgbhsv_pkg::STEPS_PER_STAGE; j++) begin
            // saturation: remainder stays below the divisor
            s2 = {v.s_rem, 1'b0};
            if (s2 >= {1'b0, v.s_div}) begin
                s2      = s2 - {1'b0, v.s_div};
                v.s_quo = {v.s_quo[rgbhsv_pkg::QUO_BITS-1:0], 1'b1};
            end else begin
                v.s_quo = {v.s_quo[rgbhsv_pkg::QUO_BITS-1:0], 1'b0};
            end
            v.s_rem = s2[rgbhsv_pkg::PIX_BITS-1:0];
            // hue
            h2 = {v.h_rem, 1'b0};
            if (h2 >= {1'b0, v.h_div}) begin
                h2      = h2 - {1'b0, v.h_div};
                v.h_quo = {v.h_quo[rgbhsv_pkg::QUO_BITS-2:0], 1'b1};
            end else begin
                v.h_quo = {v.h_quo[rgbhsv_pkg::QUO_BITS-2:0], 1'b0};
            end
            v.h_rem = h2[rgbhsv_pkg::HUE_DIV_BITS-1:0];
        end
        n_data = v;
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_data <= n_data;
        end
    end

endmodule

/* hdl/rgb_to_hsv_converter_core.sv */
// rgb to hsv converter top level: max/min front stage and pipelined dividers
// depends on rgbhsv_pkg and rgbhsv_div_stage
//
// channel  direction  handshake                 payload
// pixel    in         i_in_valid / o_in_ready   i_red, i_green, i_blue
// hsv      out        o_out_valid / i_out_ready o_hue, o_saturation, o_brightness
//
// one pixel per clock sustained while the output is not stalled; the pipe is
// one front stage plus the divider chain, each stage of which retires four
// quotient bits of both divisions.
// reset clears only the valid bits; stage payloads are not reset.
// every stage holds its beat while the next one is full and stalled, and
// empty stages fill up, so o_in_ready drops only when the whole pipe is full
// and the output beat is not taken.
module rgb_to_hsv_converter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [rgbhsv_pkg::PIX_BITS-1:0]     i_red,
    input  logic [rgbhsv_pkg::PIX_BITS-1:0]     i_green,
    input  logic [rgbhsv_pkg::PIX_BITS-1:0]     i_blue,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rgbhsv_pkg::HUE_BITS-1:0]     o_hue,
    output logic [rgbhsv_pkg::SAT_FRAC_BITS:0]  o_saturation,
    output logic [rgbhsv_pkg::PIX_BITS-1:0]     o_brightness
);

    logic             r_front_valid;
    rgbhsv_pkg::t_div r_front;
    rgbhsv_pkg::t_div n_front;
    logic             w_front_en;

    logic             w_valid [0:rgbhsv_pkg::NUM_STAGES];
    logic             w_ready [0:rgbhsv_pkg::NUM_STAGES];
    rgbhsv_pkg::t_div w_data  [0:rgbhsv_pkg::NUM_STAGES];

    // front stage: max, min, sector numerator and divisors
    always_comb begin
        logic [rgbhsv_pkg::PIX_BITS-1:0]     hi;
        logic [rgbhsv_pkg::PIX_BITS-1:0]     lo;
        logic [rgbhsv_pkg::PIX_BITS-1:0]     d;
        logic                                red_top;
        logic                                grn_top;
        logic                                q0;
        logic [rgbhsv_pkg::HUE_DIV_BITS-1:0] r11;
        logic [rgbhsv_pkg::HUE_DIV_BITS-1:0] g11;
        logic [rgbhsv_pkg::HUE_DIV_BITS-1:0] b11;
        logic [rgbhsv_pkg::HUE_DIV_BITS-1:0] d11;
        logic [rgbhsv_pkg::HUE_DIV_BITS-1:0] num;
        // red wins ties, then green
        red_top = (i_red >= i_green) && (i_red >= i_blue);
        grn_top = !red_top && (i_green >= i_blue);
        if (red_top) begin
            hi = i_red;
        end else if (grn_top) begin
            hi = i_green;
        end else begin
            hi = i_blue;
        end
        if ((i_red <= i_green) && (i_red <= i_blue)) begin
            lo = i_red;
        end else if (i_green <= i_blue) begin
            lo = i_green;
        end else begin
            lo = i_blue;
        end
        d   = hi - lo;
        r11 = rgbhsv_pkg::HUE_DIV_BITS'(i_red);
        g11 = rgbhsv_pkg::HUE_DIV_BITS'(i_green);
        b11 = rgbhsv_pkg::HUE_DIV_BITS'(i_blue);
        d11 = rgbhsv_pkg::HUE_DIV_BITS'(d);
        // numerator in units of d; modular math, true value lies in [0, 6d)
        if (red_top) begin
            if (i_green >= i_blue) begin
                num = g11 - b11;
            end else begin
                num = (d11 << 2) + (d11 << 1) + g11 - b11;
            end
        end else if (grn_top) begin
            num = (d11 << 1) + b11 - r11;
        end else begin
            num = (d11 << 2) + r11 - g11;
        end
        // integer bit of saturation is set only when min is 0 and max is not
        q0 = (hi != '0) && (lo == '0);

        n_front.s_rem    = q0 ? '0 : d;
        n_front.s_div    = (hi == '0) ? rgbhsv_pkg::PIX_BITS'(1) : hi;
        n_front.s_quo    = '0;
        n_front.s_quo[0] = q0;
        n_front.h_rem    = (d == '0) ? '0 : num;
        n_front.h_div    = (d == '0) ? rgbhsv_pkg::HUE_DIV_BITS'(6)
                                     : (d11 << 2) + (d11 << 1);
        n_front.h_quo    = '0;
        n_front.val      = hi;
    end

    assign w_front_en = !r_front_valid || w_ready[0];
    assign o_in_ready = w_front_en;

    // front valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_valid <= 1'b0;
        end else if (w_front_en) begin
            r_front_valid <= i_in_valid;
        end
    end

    // front payload
    always_ff @(posedge i_clk) begin
        if (w_front_en) begin
            r_front <= n_front;
        end
    end

    // divider chain
    assign w_valid[0]                      = r_front_valid;
    assign w_data[0]                       = r_front;
    assign w_ready[rgbhsv_pkg::NUM_STAGES] = i_out_ready;

    for (genvar k = 0; k < rgbhsv_pkg::NUM_STAGES; k++) begin : g_div
        rgbhsv_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_data  (w_data[k]),
            .o_ready (w_ready[k]),
            .o_valid (w_valid[k+1]),
            .o_data  (w_data[k+1]),
            .i_ready (w_ready[k+1])
        );
    end

    // results: drop the extra low quotient bits beyond each field's precision
    assign o_out_valid  = w_valid[rgbhsv_pkg::NUM_STAGES];
    assign o_hue        = w_data[rgbhsv_pkg::NUM_STAGES].h_quo[
                              rgbhsv_pkg::QUO_BITS-1 -: rgbhsv_pkg::HUE_BITS];
    assign o_saturation = w_data[rgbhsv_pkg::NUM_STAGES].s_quo[
                              rgbhsv_pkg::QUO_BITS -: rgbhsv_pkg::SAT_FRAC_BITS+1];
    assign o_brightness = w_data[rgbhsv_pkg::NUM_STAGES].val;

    // saturation never exceeds one
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_saturation <= rgbhsv_pkg::SAT_ONE))
        else $error("saturation above 1.0");

    // input stalls only when the whole pipe is blocked at the output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled while output side is free");

    // divisors fed to the chain are never zero
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front_valid |-> ((r_front.s_div != '0) && (r_front.h_div != '0)))
        else $error("zero divisor entered the divider");

endmodule
